[rtl/core/mpet_pkg.sv]
// ============================================================================
// mpet_pkg: shared constants and types for the escape-time block
// Field widths, configuration register indexes and the fixed-point format
// constants used by the top level and its arithmetic units.
// ============================================================================
package mpet_pkg;

    localparam int INT_BITS    = 4;
    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int DIM_W       = 13;
    localparam int COUNT_W     = 16;
    localparam int INTENSITY_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DIV_W       = 16;
    localparam int MAP_NUM_W   = 15;
    localparam int INT_NUM_W   = 27;

    localparam int RE_SCALE        = 7;
    localparam int IM_SCALE        = 5;
    localparam int INTENSITY_SCALE = 2040;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
    localparam logic [COUNT_W-1:0] MAX_IT_RESET = 16'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_MAX_ITERATIONS = 2'd2
    } t_cfg_index;

endpackage

[rtl/core/mpet_fxmul.sv]
// ============================================================================
// mpet_fxmul: shared signed fixed-point multiplier
// Multiplies magnitudes digit by digit, truncates toward zero to the fraction
// bits and saturates to the signed coordinate range.
// ============================================================================
module mpet_fxmul #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_p
);
    import mpet_pkg::*;

    localparam int F   = W - INT_BITS;
    localparam int ND  = (W > 32) ? 2 : 1;
    localparam int DG  = (W + ND - 1) / ND;
    localparam int MW  = ND * DG;
    localparam int PW  = 2 * MW;
    localparam int IW  = (ND > 1) ? $clog2(ND) : 1;
    localparam int SHW = PW - F;

    logic [MW-1:0]   r_ua, r_ub;
    logic            r_neg;
    logic [PW-1:0]   r_acc;
    logic [IW-1:0]   r_i, r_j;
    logic            r_acc_on, r_sat_on, r_done;
    logic [W-1:0]    r_p;

    logic [W-1:0]    mag_a, mag_b;
    logic [DG-1:0]   dig_a, dig_b;
    logic [2*DG-1:0] pp;
    logic [PW-1:0]   pp_shifted;
    logic            last;
    logic [SHW-1:0]  mag_sh, limit, mag_sel;
    logic [W-1:0]    res;

    assign mag_a = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign mag_b = i_b[W-1] ? (~i_b + W'(1)) : i_b;

    assign dig_a      = r_ua[r_i*DG +: DG];
    assign dig_b      = r_ub[r_j*DG +: DG];
    assign pp         = dig_a * dig_b;
    assign pp_shifted = PW'(pp) << (DG * (int'(r_i) + int'(r_j)));
    assign last       = (r_i == IW'(ND - 1)) && (r_j == IW'(ND - 1));

    assign mag_sh  = r_acc[PW-1:F];
    assign limit   = r_neg ? (SHW'(1) << (W - 1)) : ((SHW'(1) << (W - 1)) - SHW'(1));
    assign mag_sel = (mag_sh > limit) ? limit : mag_sh;
    assign res     = r_neg ? (W'(0) - mag_sel[W-1:0]) : mag_sel[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_on <= 1'b0;
            r_sat_on <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= r_sat_on;
            r_sat_on <= r_acc_on && last;
            if (i_start) begin
                r_acc_on <= 1'b1;
            end else if (r_acc_on && last) begin
                r_acc_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= MW'(mag_a);
            r_ub  <= MW'(mag_b);
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_acc <= '0;
            r_i   <= '0;
            r_j   <= '0;
        end else if (r_acc_on) begin
            r_acc <= r_acc + pp_shifted;
            if (!last) begin
                if (r_j == IW'(ND - 1)) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
        end
        if (r_sat_on) begin
            r_p <= res;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

[rtl/core/mpet_div.sv]
// ============================================================================
// mpet_div: shared restoring divider
// Long division of a left-aligned dividend, one quotient bit per cycle, with
// the quotient saturated to its register width.
// ============================================================================
module mpet_div #(
    parameter int QW = 31,
    parameter int NW = 42
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NW-1:0]              i_num,
    input  logic [$clog2(NW+1)-1:0]    i_steps,
    input  logic [mpet_pkg::DIV_W-1:0] i_den,
    output logic                       o_done,
    output logic [QW-1:0]              o_quot
);
    import mpet_pkg::*;

    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DIV_W-1:0] r_den, r_rem;
    logic [QW-1:0]    r_q;
    logic             r_ovf;
    logic [SW-1:0]    r_left;
    logic             r_busy, r_done;

    logic [DIV_W:0]   trial, diff;
    logic             ge;
    logic [DIV_W-1:0] rem_n;
    logic             last;

    assign trial = {r_rem, r_num[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};
    assign rem_n = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    assign last  = r_left == SW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_left <= i_steps;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= rem_n;
            r_q    <= {r_q[QW-2:0], ge};
            r_ovf  <= r_ovf | r_q[QW-1];
            r_left <= r_left - SW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? {QW{1'b1}} : r_q;

endmodule

[rtl/core/mandelbrot_pixel_escape_time.sv]
// ============================================================================
// mandelbrot_pixel_escape_time: escape-time count for one pixel
// Maps a pixel to a point c, iterates z = z*z + c in signed fixed point and
// returns the iteration count and a scaled intensity.
//
// Channel   Direction  Handshake           Payload
// pixel     in         i_valid / o_ready   i_pixel_column, i_pixel_row
// result    out        o_valid / i_ready   o_iteration_count, o_intensity
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// Each iteration uses up to three products on the shared multiplier, and each
// transaction also takes two mapping divisions and one intensity division on
// the shared divider. Above 32 coordinate bits each product is built from two
// digits per operand.
// Reset is synchronous and restores the register defaults.
// A waiting result does not block the next pixel until its own result is due.
// ============================================================================
module mandelbrot_pixel_escape_time #(
    parameter int COORD_WIDTH   = 32,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mpet_pkg::COL_W-1:0]       i_pixel_column,
    input  logic [mpet_pkg::ROW_W-1:0]       i_pixel_row,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [mpet_pkg::COUNT_W-1:0]     o_iteration_count,
    output logic [mpet_pkg::INTENSITY_W-1:0] o_intensity,
    input  logic                             i_cfg_we,
    input  logic [mpet_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mpet_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpet_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = W - INT_BITS;
    localparam int NDV = MAP_NUM_W + F - 1;
    localparam int SW  = $clog2(NDV + 1);

    localparam logic [W-1:0] POS_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] RE_OFS   = W'(5) << (F - 1);
    localparam logic [W-1:0] IM_OFS   = W'(5) << (F - 2);
    localparam logic [W:0]   ESC_BND  = (W+1)'(1) << (W - 2);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_DIV_RE  = 8'b00000010,
        S_DIV_IM  = 8'b00000100,
        S_SQ_A    = 8'b00001000,
        S_SQ_B    = 8'b00010000,
        S_CROSS   = 8'b00100000,
        S_DIV_INT = 8'b01000000,
        S_FINISH  = 8'b10000000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_first;
    logic [DIM_W-1:0]       r_width, r_height;
    logic [COUNT_W-1:0]     r_max;
    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic [W-1:0]           r_ca, r_cb, r_za, r_zb, r_sa, r_dif;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_o_valid;
    logic [COUNT_W-1:0]     r_o_count;
    logic [INTENSITY_W-1:0] r_o_intensity;

    logic                   accept, finish, stop;
    logic                   mul_start, mul_done;
    logic [W-1:0]           mul_a, mul_b, mul_p;
    logic                   div_start, div_done;
    logic [NDV-1:0]         div_num;
    logic [SW-1:0]          div_steps;
    logic [DIV_W-1:0]       div_den;
    logic [W-2:0]           div_quot;
    logic [MAP_NUM_W-1:0]   re_num, im_num;
    logic [INT_NUM_W-1:0]   int_num;
    logic [W-1:0]           quot_ext, dbl;
    logic [W:0]             sq_sum, sum_a, sum_b;

    function automatic logic [DIV_W-1:0] f_dim_div(input logic [DIM_W-1:0] dim);
        logic [31:0] d;
        d = 32'(dim);
        if (d < 32'd2) begin
            d = 32'd2;
        end
        if (d > 32'(MAX_DIMENSION)) begin
            d = 32'(MAX_DIMENSION);
        end
        return DIV_W'(d - 32'd1);
    endfunction

    function automatic logic [W-1:0] f_sat(input logic [W:0] x);
        if (x[W] != x[W-1]) begin
            return x[W] ? NEG_MIN : POS_MAX;
        end
        return x[W-1:0];
    endfunction

    assign accept = i_valid && o_ready;
    assign finish = (r_state == S_FINISH) && (!r_o_valid || i_ready);

    // Shared multiplier
    assign mul_start = r_first && ((r_state == S_SQ_A) || (r_state == S_SQ_B) ||
                                   (r_state == S_CROSS));
    assign mul_a     = (r_state == S_SQ_B) ? r_zb : r_za;
    assign mul_b     = (r_state == S_SQ_A) ? r_za : r_zb;

    mpet_fxmul #(
        .W (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // Shared divider
    assign re_num  = MAP_NUM_W'(r_col) * MAP_NUM_W'(RE_SCALE);
    assign im_num  = MAP_NUM_W'(r_row) * MAP_NUM_W'(IM_SCALE);
    assign int_num = INT_NUM_W'(r_count) * INT_NUM_W'(INTENSITY_SCALE);

    assign div_start = r_first && ((r_state == S_DIV_RE) || (r_state == S_DIV_IM) ||
                                   (r_state == S_DIV_INT));

    always_comb begin
        case (r_state)
            S_DIV_RE: begin
                div_num   = {re_num, {(F-1){1'b0}}};
                div_steps = SW'(NDV);
                div_den   = f_dim_div(r_width);
            end
            S_DIV_IM: begin
                div_num   = {im_num, {(F-1){1'b0}}};
                div_steps = SW'(NDV);
                div_den   = f_dim_div(r_height);
            end
            default: begin
                div_num   = {int_num, {(NDV-INT_NUM_W){1'b0}}};
                div_steps = SW'(INT_NUM_W);
                div_den   = r_max;
            end
        endcase
    end

    mpet_div #(
        .QW (W - 1),
        .NW (NDV)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_steps (div_steps),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Iteration datapath
    assign quot_ext = {1'b0, div_quot};
    assign sq_sum   = {1'b0, r_sa} + {1'b0, mul_p};
    assign stop     = (r_count >= r_max) || (sq_sum >= ESC_BND);
    assign dbl      = (mul_p[W-1] != mul_p[W-2]) ? (mul_p[W-1] ? NEG_MIN : POS_MAX)
                                                 : {mul_p[W-2:0], 1'b0};
    assign sum_b    = {dbl[W-1], dbl} + {r_cb[W-1], r_cb};
    assign sum_a    = {r_dif[W-1], r_dif} + {r_ca[W-1], r_ca};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DIV_RE;
                end
            end
            S_DIV_RE: begin
                if (div_done) begin
                    n_state = S_DIV_IM;
                end
            end
            S_DIV_IM: begin
                if (div_done) begin
                    n_state = S_SQ_A;
                end
            end
            S_SQ_A: begin
                if (mul_done) begin
                    n_state = S_SQ_B;
                end
            end
            S_SQ_B: begin
                if (mul_done) begin
                    n_state = stop ? S_DIV_INT : S_CROSS;
                end
            end
            S_CROSS: begin
                if (mul_done) begin
                    n_state = S_SQ_A;
                end
            end
            S_DIV_INT: begin
                if (div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_o_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_first   <= 1'b0;
            r_o_valid <= 1'b0;
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_max     <= MAX_IT_RESET;
        end else begin
            r_state <= n_state;
            r_first <= n_state != r_state;
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data[DIM_W-1:0];
                    CFG_MAX_ITERATIONS: r_max    <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= i_pixel_column;
            r_row <= i_pixel_row;
        end
        if ((r_state == S_DIV_RE) && div_done) begin
            r_ca <= quot_ext - RE_OFS;
        end
        if ((r_state == S_DIV_IM) && div_done) begin
            r_cb    <= IM_OFS - quot_ext;
            r_za    <= '0;
            r_zb    <= '0;
            r_count <= '0;
        end
        if ((r_state == S_SQ_A) && mul_done) begin
            r_sa <= mul_p;
        end
        if ((r_state == S_SQ_B) && mul_done) begin
            r_dif <= r_sa - mul_p;
        end
        if ((r_state == S_CROSS) && mul_done) begin
            r_za    <= f_sat(sum_a);
            r_zb    <= f_sat(sum_b);
            r_count <= r_count + COUNT_W'(1);
        end
        if (finish) begin
            r_o_count     <= r_count;
            r_o_intensity <= (r_max == '0) ? '0 : div_quot[INTENSITY_W-1:0];
        end
    end

    assign o_ready           = r_state == S_IDLE;
    assign o_valid           = r_o_valid;
    assign o_iteration_count = r_o_count;
    assign o_intensity       = r_o_intensity;

    // The multiplier reports a product only while a product state waits for it.
    a_mul_done_in_mul_state: assert property (@(posedge i_clk)
        mul_done |-> ((r_state == S_SQ_A) || (r_state == S_SQ_B) || (r_state == S_CROSS)))
        else $error("multiplier result outside a product state");

    // The divider reports a quotient only while a division state waits for it.
    a_div_done_in_div_state: assert property (@(posedge i_clk)
        div_done |-> ((r_state == S_DIV_RE) || (r_state == S_DIV_IM) ||
                      (r_state == S_DIV_INT)))
        else $error("divider result outside a division state");

    // An accepted transaction launches the real-axis division in the next cycle.
    a_accept_starts_div: assert property (@(posedge i_clk)
        (i_rst_n && i_valid && o_ready) |=> ((r_state == S_DIV_RE) && r_first))
        else $error("accepted pixel did not start the mapping division");

    // A new result appears only when the sequencer finishes a pixel.
    a_result_from_finish: assert property (@(posedge i_clk)
        $rose(o_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside the finish state");

endmodule
